### design/rtpd_pkg.sv
// shared types and constants of the rtp h264 depacketizer
`default_nettype none

package rtpd_pkg;

  localparam int unsigned MAX_PACKET_BYTES = 2048;
  localparam int unsigned CMD_DEPTH = 4;
  localparam logic [4:0] NAL_TYPE_STAP_A = 5'd24;
  localparam logic [4:0] NAL_TYPE_FU_A = 5'd28;
  localparam logic [6:0] RTP_FIXED_HDR = 7'd12;
  localparam logic [7:0] START_CODE [4] = '{8'h00, 8'h00, 8'h00, 8'h01};

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_START  = 2'd1,
    ST_UNSUPP    = 2'd2,
    ST_TRUNC     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    PH_HDR       = 3'd0,
    PH_NAL       = 3'd1,
    PH_SINGLE    = 3'd2,
    PH_STAP_SIZE = 3'd3,
    PH_STAP_DATA = 3'd4,
    PH_FU_HDR    = 3'd5,
    PH_FU_DATA   = 3'd6,
    PH_SKIP      = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    STEP_SC0   = 3'd0,
    STEP_SC1   = 3'd1,
    STEP_SC2   = 3'd2,
    STEP_SC3   = 3'd3,
    STEP_MAIN  = 3'd4,
    STEP_TRUNC = 3'd5
  } step_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       packet_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       frame_start;
    logic       frame_end;
    status_e    status;
    logic       run_last;
  } out_item_t;

  // work for one accepted byte: optional start code, optional main result,
  // optional trailing truncation report
  typedef struct packed {
    logic       sc;
    logic       sc_fs;
    logic       main;
    logic [7:0] m_byte;
    logic       m_valid;
    logic       m_fs;
    logic       m_fe;
    status_e    m_status;
    logic       trunc;
  } cmd_t;

endpackage

`default_nettype wire

### design/rtpd_front.sv
// packet parser that turns each byte into a result command
`default_nettype none

module rtpd_front #(
  parameter int unsigned MaxPacketBytes = rtpd_pkg::MAX_PACKET_BYTES
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire rtpd_pkg::in_item_t in_i,
  input  wire logic               psc_i,
  output logic                    cmd_valid_o,
  output rtpd_pkg::cmd_t          cmd_o
);

  localparam int unsigned PosW = $clog2(MaxPacketBytes + 1);
  localparam int unsigned CmpW = PosW + 1;
  localparam logic [PosW-1:0] PosMax = PosW'(MaxPacketBytes);

  rtpd_pkg::phase_e phase_q, phase_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [6:0]       hdr_len_q, hdr_len_d;
  logic [15:0]      left_q, left_d;
  logic [7:0]       size_hi_q, size_hi_d;
  logic             frag_q, frag_d;
  logic [2:0]       ind_q, ind_d;
  logic             endp_q, endp_d;

  logic [7:0]  b;
  logic        last;
  logic [15:0] size;
  logic [15:0] left_dec;
  rtpd_pkg::cmd_t cmd;

  assign b        = in_i.in_byte;
  assign last     = in_i.packet_last;
  assign size     = {size_hi_q, b};
  assign left_dec = left_q - 16'd1;

  always_comb begin
    cmd       = '0;
    phase_d   = phase_q;
    pos_d     = pos_q;
    hdr_len_d = hdr_len_q;
    left_d    = left_q;
    size_hi_d = size_hi_q;
    frag_d    = frag_q;
    ind_d     = ind_q;
    endp_d    = endp_q;

    if (phase_q != rtpd_pkg::PH_SKIP && pos_q >= PosMax) begin
      cmd.main     = 1'b1;
      cmd.m_status = rtpd_pkg::ST_TRUNC;
      frag_d       = 1'b0;
      phase_d      = rtpd_pkg::PH_SKIP;
    end else begin
      unique case (phase_q)
        rtpd_pkg::PH_HDR: begin
          if (pos_q == '0) begin
            hdr_len_d = rtpd_pkg::RTP_FIXED_HDR + {1'b0, b[3:0], 2'b00};
          end
          if ((CmpW'(pos_q) + CmpW'(1)) >= CmpW'(hdr_len_d)) begin
            phase_d = rtpd_pkg::PH_NAL;
          end
          if (last) begin
            cmd.main     = 1'b1;
            cmd.m_status = rtpd_pkg::ST_TRUNC;
            frag_d       = 1'b0;
          end
        end
        rtpd_pkg::PH_NAL: begin
          if (b[4:0] < rtpd_pkg::NAL_TYPE_STAP_A) begin
            frag_d      = 1'b0;
            cmd.sc      = psc_i;
            cmd.sc_fs   = 1'b1;
            cmd.main    = 1'b1;
            cmd.m_byte  = b;
            cmd.m_valid = 1'b1;
            cmd.m_fs    = !psc_i;
            cmd.m_fe    = last;
            phase_d     = rtpd_pkg::PH_SINGLE;
          end else if (b[4:0] == rtpd_pkg::NAL_TYPE_STAP_A) begin
            frag_d    = 1'b0;
            endp_d    = 1'b0;
            left_d    = '0;
            phase_d   = rtpd_pkg::PH_STAP_SIZE;
            cmd.trunc = last;
          end else if (b[4:0] == rtpd_pkg::NAL_TYPE_FU_A) begin
            ind_d   = b[7:5];
            phase_d = rtpd_pkg::PH_FU_HDR;
            if (last) begin
              cmd.trunc = 1'b1;
              frag_d    = 1'b0;
            end
          end else begin
            cmd.main     = 1'b1;
            cmd.m_status = rtpd_pkg::ST_UNSUPP;
            phase_d      = rtpd_pkg::PH_SKIP;
          end
        end
        rtpd_pkg::PH_SINGLE: begin
          cmd.main    = 1'b1;
          cmd.m_byte  = b;
          cmd.m_valid = 1'b1;
          cmd.m_fe    = last;
        end
        rtpd_pkg::PH_STAP_SIZE: begin
          if (left_q == '0) begin
            size_hi_d = b;
            left_d    = 16'd1;
          end else if (size == '0) begin
            left_d = '0;
          end else begin
            left_d  = size;
            phase_d = rtpd_pkg::PH_STAP_DATA;
            if (psc_i) begin
              cmd.sc    = 1'b1;
              cmd.sc_fs = !endp_q;
              endp_d    = 1'b1;
            end
          end
          cmd.trunc = last;
        end
        rtpd_pkg::PH_STAP_DATA: begin
          endp_d      = 1'b1;
          left_d      = left_dec;
          cmd.main    = 1'b1;
          cmd.m_byte  = b;
          cmd.m_valid = 1'b1;
          cmd.m_fs    = !endp_q;
          cmd.m_fe    = last && (left_dec == '0);
          if (left_dec == '0) begin
            phase_d = rtpd_pkg::PH_STAP_SIZE;
          end
          cmd.trunc = last && (left_dec != '0);
        end
        rtpd_pkg::PH_FU_HDR: begin
          if (b[7]) begin
            frag_d      = !(last && b[6]);
            endp_d      = b[6];
            cmd.sc      = psc_i;
            cmd.sc_fs   = 1'b1;
            cmd.main    = 1'b1;
            cmd.m_byte  = {ind_q, b[4:0]};
            cmd.m_valid = 1'b1;
            cmd.m_fs    = !psc_i;
            cmd.m_fe    = last && b[6];
            phase_d     = rtpd_pkg::PH_FU_DATA;
          end else if (!frag_q) begin
            cmd.main     = 1'b1;
            cmd.m_status = rtpd_pkg::ST_NO_START;
            phase_d      = rtpd_pkg::PH_SKIP;
          end else begin
            endp_d  = b[6];
            phase_d = rtpd_pkg::PH_FU_DATA;
            if (last && b[6]) begin
              cmd.main = 1'b1;
              cmd.m_fe = 1'b1;
              frag_d   = 1'b0;
            end
          end
        end
        rtpd_pkg::PH_FU_DATA: begin
          cmd.main    = 1'b1;
          cmd.m_byte  = b;
          cmd.m_valid = 1'b1;
          cmd.m_fe    = last && endp_q;
          if (last && endp_q) begin
            frag_d = 1'b0;
          end
        end
        rtpd_pkg::PH_SKIP: begin
        end
        default: begin
        end
      endcase
    end

    if (last) begin
      phase_d = rtpd_pkg::PH_HDR;
      pos_d   = '0;
      left_d  = '0;
      endp_d  = 1'b0;
    end else if (pos_q < PosMax) begin
      pos_d = pos_q + PosW'(1);
    end
  end

  assign cmd_o       = cmd;
  assign cmd_valid_o = accept_i && (cmd.sc || cmd.main || cmd.trunc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= rtpd_pkg::PH_HDR;
      pos_q     <= '0;
      hdr_len_q <= rtpd_pkg::RTP_FIXED_HDR;
      left_q    <= '0;
      size_hi_q <= '0;
      frag_q    <= 1'b0;
      ind_q     <= '0;
      endp_q    <= 1'b0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      hdr_len_q <= hdr_len_d;
      left_q    <= left_d;
      size_hi_q <= size_hi_d;
      frag_q    <= frag_d;
      ind_q     <= ind_d;
      endp_q    <= endp_d;
    end
  end

endmodule

`default_nettype wire

### design/rtpd_cmd_fifo.sv
// small command queue between parser and result sequencer
`default_nettype none

module rtpd_cmd_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire rtpd_pkg::cmd_t  data_i,
  input  wire logic            pop_i,
  output logic                 full_o,
  output logic                 valid_o,
  output rtpd_pkg::cmd_t       data_o
);

  localparam int unsigned Depth = rtpd_pkg::CMD_DEPTH;
  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  rtpd_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? ((wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1)) : wr_q;
    rd_d  = do_pop ? ((rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1)) : rd_q;
    cnt_d = cnt_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### design/rtpd_back.sv
// result sequencer that expands commands into stream transactions
`default_nettype none

module rtpd_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cmd_valid_i,
  input  wire rtpd_pkg::cmd_t  cmd_i,
  output logic                 cmd_pop_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output rtpd_pkg::out_item_t  out_o
);

  rtpd_pkg::step_e     step_q, step_d, cur, nxt;
  logic                busy_q, busy_d;
  logic                done;
  logic                load;
  rtpd_pkg::out_item_t res;
  rtpd_pkg::out_item_t out_q;
  logic                out_valid_q;

  always_comb begin
    if (busy_q) begin
      cur = step_q;
    end else if (cmd_i.sc) begin
      cur = rtpd_pkg::STEP_SC0;
    end else if (cmd_i.main) begin
      cur = rtpd_pkg::STEP_MAIN;
    end else begin
      cur = rtpd_pkg::STEP_TRUNC;
    end

    nxt  = rtpd_pkg::STEP_TRUNC;
    done = 1'b0;
    res  = '0;
    unique case (cur)
      rtpd_pkg::STEP_SC0, rtpd_pkg::STEP_SC1, rtpd_pkg::STEP_SC2: begin
        nxt              = rtpd_pkg::step_e'(3'(cur) + 3'd1);
        res.out_byte     = rtpd_pkg::START_CODE[cur[1:0]];
        res.byte_valid   = 1'b1;
        res.frame_start  = (cur == rtpd_pkg::STEP_SC0) && cmd_i.sc_fs;
      end
      rtpd_pkg::STEP_SC3: begin
        nxt            = cmd_i.main ? rtpd_pkg::STEP_MAIN : rtpd_pkg::STEP_TRUNC;
        done           = !cmd_i.main && !cmd_i.trunc;
        res.out_byte   = rtpd_pkg::START_CODE[cur[1:0]];
        res.byte_valid = 1'b1;
      end
      rtpd_pkg::STEP_MAIN: begin
        done            = !cmd_i.trunc;
        res.out_byte    = cmd_i.m_byte;
        res.byte_valid  = cmd_i.m_valid;
        res.frame_start = cmd_i.m_fs;
        res.frame_end   = cmd_i.m_fe;
        res.status      = cmd_i.m_status;
      end
      rtpd_pkg::STEP_TRUNC: begin
        done       = 1'b1;
        res.status = rtpd_pkg::ST_TRUNC;
      end
      default: begin
        done = 1'b1;
      end
    endcase
    res.run_last = done;
  end

  assign load      = cmd_valid_i && (!out_valid_q || pop_i);
  assign cmd_pop_o = load && done;
  assign empty_o   = !out_valid_q;
  assign out_o     = out_q;

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (load) begin
      busy_d = !done;
      step_d = nxt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= rtpd_pkg::STEP_SC0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### design/rtp_h264_depacketizer_unit.sv
// top level of the rtp h264 depacketizer
//
// input queue side: one rtp packet byte per transaction, header first, with
// packet_last on the final byte; a transaction completes when push_i is high
// and full_o is low. result queue side: the oldest result sits on out_o while
// empty_o is low and is taken when pop_i is high.
// the parser takes one byte per cycle while full_o is low and classifies it
// into a command; a four-entry command queue feeds the sequencer, which emits
// one result per cycle while out_o is empty or being taken (up to five per
// byte: start code plus data or status). the first result of a byte passes
// through the command queue and then the output register to reach out_o.
// sustained rate is one byte per cycle while each byte gives at most one
// result and pop_i stays high; a byte that carries a start code gives four
// or five results, and full_o rises once the command queue fills.
// when the receiver stalls, the output register holds its result, the
// command queue fills and then full_o holds off the sender.
// reset empties both queues, returns the parser to the rtp header and sets
// the start code prefix enable to one; cfg_we_i writes it at any edge.
`default_nettype none

module rtp_h264_depacketizer_unit #(
  parameter int unsigned MaxPacketBytes = rtpd_pkg::MAX_PACKET_BYTES
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_wdata_i,
  input  wire logic                push_i,
  output logic                     full_o,
  input  wire rtpd_pkg::in_item_t  in_i,
  input  wire logic                pop_i,
  output logic                     empty_o,
  output rtpd_pkg::out_item_t      out_o
);

  logic           psc_q;
  logic           accept;
  logic           cmd_push;
  rtpd_pkg::cmd_t cmd_in;
  logic           cmd_valid;
  rtpd_pkg::cmd_t cmd_head;
  logic           cmd_pop;

  assign accept = push_i && !full_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      psc_q <= 1'b1;
    end else if (cfg_we_i) begin
      psc_q <= cfg_wdata_i;
    end
  end

  rtpd_front #(
    .MaxPacketBytes(MaxPacketBytes)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_i       (in_i),
    .psc_i      (psc_q),
    .cmd_valid_o(cmd_push),
    .cmd_o      (cmd_in)
  );

  rtpd_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_in),
    .pop_i  (cmd_pop),
    .full_o (full_o),
    .valid_o(cmd_valid),
    .data_o (cmd_head)
  );

  rtpd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd_head),
    .cmd_pop_o  (cmd_pop),
    .pop_i      (pop_i),
    .empty_o    (empty_o),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

### bench/rtp_h264_depacketizer_unit_test.sv
// self-checking testbench of the rtp h264 depacketizer unit with random packet traffic
`timescale 1ns / 100ps

module rtp_h264_depacketizer_unit_test;

  localparam int unsigned IdleLimit = 3000;
  localparam int unsigned LongHold = 400;
  localparam int unsigned PhaseBytes = 125;

  class annexb_scoreboard;
    rtpd_pkg::out_item_t annexb_q[$];
    rtpd_pkg::out_item_t burst[$];
    int unsigned mismatches;
    bit prefix_en;
    rtpd_pkg::phase_e phase;
    logic [11:0] byte_pos;
    logic [6:0] hdr_len;
    logic [15:0] unit_left;
    logic [7:0] size_hi;
    bit frag_open;
    logic [2:0] nri_bits;
    bit end_pending;

    function new();
      mismatches = 0;
      prefix_en = 1'b1;
      phase = rtpd_pkg::PH_HDR;
      byte_pos = '0;
      hdr_len = rtpd_pkg::RTP_FIXED_HDR;
      unit_left = '0;
      size_hi = '0;
      frag_open = 1'b0;
      nri_bits = '0;
      end_pending = 1'b0;
    endfunction

    function int pending();
      return annexb_q.size();
    endfunction

    function void emit(logic [7:0] b, bit valid, bit fs, bit fe, rtpd_pkg::status_e st);
      rtpd_pkg::out_item_t r;
      r.out_byte = b;
      r.byte_valid = valid;
      r.frame_start = fs;
      r.frame_end = fe;
      r.status = st;
      r.run_last = 1'b0;
      burst.push_back(r);
    endfunction

    function void emit_status(rtpd_pkg::status_e st);
      emit(8'h00, 1'b0, 1'b0, 1'b0, st);
    endfunction

    function void emit_start_code(bit fs);
      if (!prefix_en) return;
      for (int i = 0; i < 4; i++) begin
        emit(rtpd_pkg::START_CODE[i], 1'b1, (i == 0) ? fs : 1'b0, 1'b0, rtpd_pkg::ST_OK);
      end
    endfunction

    // works out the stream bytes caused by one accepted packet byte
    function void note_packet_byte(rtpd_pkg::in_item_t item);
      logic [7:0] b;
      bit pkt_last;
      logic [15:0] size;
      bit fs;
      bit done;
      b = item.in_byte;
      pkt_last = item.packet_last;
      burst.delete();
      if (phase != rtpd_pkg::PH_SKIP && byte_pos >= rtpd_pkg::MAX_PACKET_BYTES) begin
        emit_status(rtpd_pkg::ST_TRUNC);
        frag_open = 1'b0;
        phase = rtpd_pkg::PH_SKIP;
      end else begin
        case (phase)
          rtpd_pkg::PH_HDR: begin
            if (byte_pos == 0) hdr_len = rtpd_pkg::RTP_FIXED_HDR + {1'b0, b[3:0], 2'b00};
            if (byte_pos + 1 >= hdr_len) phase = rtpd_pkg::PH_NAL;
            if (pkt_last) begin
              emit_status(rtpd_pkg::ST_TRUNC);
              frag_open = 1'b0;
            end
          end
          rtpd_pkg::PH_NAL: begin
            if (b[4:0] < rtpd_pkg::NAL_TYPE_STAP_A) begin
              frag_open = 1'b0;
              emit_start_code(1'b1);
              emit(b, 1'b1, !prefix_en, pkt_last, rtpd_pkg::ST_OK);
              phase = rtpd_pkg::PH_SINGLE;
            end else if (b[4:0] == rtpd_pkg::NAL_TYPE_STAP_A) begin
              frag_open = 1'b0;
              end_pending = 1'b0;
              unit_left = '0;
              phase = rtpd_pkg::PH_STAP_SIZE;
              if (pkt_last) emit_status(rtpd_pkg::ST_TRUNC);
            end else if (b[4:0] == rtpd_pkg::NAL_TYPE_FU_A) begin
              nri_bits = b[7:5];
              phase = rtpd_pkg::PH_FU_HDR;
              if (pkt_last) begin
                emit_status(rtpd_pkg::ST_TRUNC);
                frag_open = 1'b0;
              end
            end else begin
              emit_status(rtpd_pkg::ST_UNSUPP);
              phase = rtpd_pkg::PH_SKIP;
            end
          end
          rtpd_pkg::PH_SINGLE: emit(b, 1'b1, 1'b0, pkt_last, rtpd_pkg::ST_OK);
          rtpd_pkg::PH_STAP_SIZE: begin
            if (unit_left == 0) begin
              size_hi = b;
              unit_left = 16'd1;
            end else begin
              size = {size_hi, b};
              if (size == 0) begin
                unit_left = '0;
              end else begin
                unit_left = size;
                phase = rtpd_pkg::PH_STAP_DATA;
                if (prefix_en) begin
                  emit_start_code(!end_pending);
                  end_pending = 1'b1;
                end
              end
            end
            if (pkt_last) emit_status(rtpd_pkg::ST_TRUNC);
          end
          rtpd_pkg::PH_STAP_DATA: begin
            fs = !end_pending;
            end_pending = 1'b1;
            unit_left = unit_left - 16'd1;
            done = (unit_left == 0);
            emit(b, 1'b1, fs, pkt_last && done, rtpd_pkg::ST_OK);
            if (done) phase = rtpd_pkg::PH_STAP_SIZE;
            if (pkt_last && !done) emit_status(rtpd_pkg::ST_TRUNC);
          end
          rtpd_pkg::PH_FU_HDR: begin
            if (b[7]) begin
              frag_open = 1'b1;
              end_pending = b[6];
              emit_start_code(1'b1);
              emit({nri_bits, b[4:0]}, 1'b1, !prefix_en, pkt_last && b[6],
                   rtpd_pkg::ST_OK);
              if (pkt_last && b[6]) frag_open = 1'b0;
              phase = rtpd_pkg::PH_FU_DATA;
            end else if (!frag_open) begin
              emit_status(rtpd_pkg::ST_NO_START);
              phase = rtpd_pkg::PH_SKIP;
            end else begin
              end_pending = b[6];
              phase = rtpd_pkg::PH_FU_DATA;
              if (pkt_last && b[6]) begin
                emit(8'h00, 1'b0, 1'b0, 1'b1, rtpd_pkg::ST_OK);
                frag_open = 1'b0;
              end
            end
          end
          rtpd_pkg::PH_FU_DATA: begin
            emit(b, 1'b1, 1'b0, pkt_last && end_pending, rtpd_pkg::ST_OK);
            if (pkt_last && end_pending) frag_open = 1'b0;
          end
          default: ;
        endcase
      end
      if (pkt_last) begin
        phase = rtpd_pkg::PH_HDR;
        byte_pos = '0;
        unit_left = '0;
        end_pending = 1'b0;
      end else if (byte_pos < rtpd_pkg::MAX_PACKET_BYTES) begin
        byte_pos = byte_pos + 12'd1;
      end
      if (burst.size() > 0) burst[burst.size() - 1].run_last = 1'b1;
      foreach (burst[i]) annexb_q.push_back(burst[i]);
    endfunction

    task report_mismatch(string what);
      if (mismatches < 100) $display("%0t mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    task check_result(rtpd_pkg::out_item_t got);
      rtpd_pkg::out_item_t want;
      if (annexb_q.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", got));
        return;
      end
      want = annexb_q.pop_front();
      if (got.out_byte !== want.out_byte)
        report_mismatch($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
      if (got.byte_valid !== want.byte_valid)
        report_mismatch($sformatf("byte_valid %b, want %b", got.byte_valid, want.byte_valid));
      if (got.frame_start !== want.frame_start)
        report_mismatch($sformatf("frame_start %b, want %b", got.frame_start, want.frame_start));
      if (got.frame_end !== want.frame_end)
        report_mismatch($sformatf("frame_end %b, want %b", got.frame_end, want.frame_end));
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.run_last !== want.run_last)
        report_mismatch($sformatf("run_last %b, want %b", got.run_last, want.run_last));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;
  logic push_i;
  logic full_o;
  rtpd_pkg::in_item_t in_i;
  logic pop_i;
  logic empty_o;
  rtpd_pkg::out_item_t out_o;

  annexb_scoreboard sb = new();
  logic [7:0] pkt[$];
  bit calm = 1'b0;
  bit hold_request = 1'b0;
  int unsigned sent_bytes = 0;
  int unsigned idle_cycles = 0;

  rtp_h264_depacketizer_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push_i),
    .full_o      (full_o),
    .in_i        (in_i),
    .pop_i       (pop_i),
    .empty_o     (empty_o),
    .out_o       (out_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni || (push_i && !full_o) || (pop_i && !empty_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int unsigned hold_cnt;
    hold_cnt = 0;
    pop_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (pop_i && !empty_o) sb.check_result(out_o);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_cnt = LongHold;
      end else if (hold_cnt == 0 && !calm && $urandom_range(0, 9) == 0) begin
        hold_cnt = $urandom_range(1, 14);
      end
      if (hold_cnt > 0) begin
        pop_i <= 1'b0;
        hold_cnt--;
      end else begin
        pop_i <= 1'b1;
      end
    end
  end

  task push_byte(logic [7:0] b, bit pkt_last);
    rtpd_pkg::in_item_t item;
    item.in_byte = b;
    item.packet_last = pkt_last;
    push_i <= 1'b1;
    in_i <= item;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    sb.note_packet_byte(item);
    sent_bytes++;
  endtask

  task send_packet();
    foreach (pkt[i]) begin
      if (!calm && $urandom_range(0, 7) == 0) begin
        push_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
      push_byte(pkt[i], i == pkt.size() - 1);
    end
  endtask

  task settle();
    push_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task set_prefix(bit en);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= en;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.prefix_en = en;
  endtask

  function void add_payload(int unsigned n);
    repeat (n) pkt.push_back(8'($urandom_range(0, 255)));
  endfunction

  function void add_header();
    logic [3:0] cc;
    cc = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd0;
    pkt.delete();
    pkt.push_back({4'($urandom_range(0, 15)), cc});
    add_payload(11 + 4 * cc);
  endfunction

  function void maybe_cut(int unsigned one_in);
    int unsigned n;
    if ($urandom_range(1, one_in) == 1) begin
      n = $urandom_range(1, pkt.size());
      while (pkt.size() > n) void'(pkt.pop_back());
    end
  endfunction

  task send_fu_frame();
    int unsigned mode;
    int unsigned nfrag;
    logic [4:0] unit_type;
    bit s_bit;
    bit e_bit;
    mode = $urandom_range(0, 9);
    nfrag = (mode == 0) ? 1 : $urandom_range(2, 4);
    unit_type = 5'($urandom_range(0, 31));
    for (int k = 0; k < nfrag; k++) begin
      s_bit = (k == 0) && (mode != 1);
      e_bit = (k == nfrag - 1) && (mode != 2);
      add_header();
      pkt.push_back({3'($urandom_range(0, 7)), rtpd_pkg::NAL_TYPE_FU_A});
      pkt.push_back({s_bit, e_bit, 1'($urandom_range(0, 1)), unit_type});
      add_payload($urandom_range(0, 8));
      maybe_cut(15);
      send_packet();
    end
  endtask

  task send_other_packet();
    int unsigned kind;
    logic [15:0] size;
    logic [4:0] unit_type;
    kind = $urandom_range(0, 99);
    add_header();
    if (kind < 35) begin
      pkt.push_back({3'($urandom_range(0, 7)), 5'($urandom_range(0, 23))});
      add_payload($urandom_range(0, 10));
    end else if (kind < 70) begin
      pkt.push_back({3'($urandom_range(0, 7)), rtpd_pkg::NAL_TYPE_STAP_A});
      repeat ($urandom_range(0, 3)) begin
        if ($urandom_range(0, 19) == 0) size = 16'($urandom_range(0, 65535));
        else if ($urandom_range(0, 9) == 0) size = 16'd0;
        else size = 16'($urandom_range(1, 6));
        pkt.push_back(size[15:8]);
        pkt.push_back(size[7:0]);
        add_payload(size > 8 ? $urandom_range(0, 8) : size);
      end
    end else if (kind < 82) begin
      unit_type = 5'($urandom_range(25, 31));
      if (unit_type == rtpd_pkg::NAL_TYPE_FU_A) unit_type = 5'd29;
      pkt.push_back({3'($urandom_range(0, 7)), unit_type});
      add_payload($urandom_range(0, 6));
    end else begin
      pkt.delete();
      add_payload($urandom_range(1, 20));
    end
    maybe_cut(10);
    send_packet();
  endtask

  initial begin
    int unsigned phase_end;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= 1'b0;
    push_i <= 1'b0;
    in_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // header cut short, unsupported type, continuation with no open frame
    pkt.delete();
    pkt.push_back(8'hFF);
    send_packet();
    pkt.delete();
    pkt.push_back(8'h80);
    repeat (11) pkt.push_back(8'h00);
    pkt.push_back(8'hFF);
    send_packet();
    void'(pkt.pop_back());
    pkt.push_back({3'd3, rtpd_pkg::NAL_TYPE_FU_A});
    pkt.push_back(8'h05);
    pkt.push_back(8'hAA);
    send_packet();

    for (int p = 0; p < 4; p++) begin
      settle();
      set_prefix(p[0]);
      calm = (p == 3);
      if (p == 1) hold_request = 1'b1;
      phase_end = sent_bytes + PhaseBytes;
      while (sent_bytes < phase_end) begin
        if ((p == 1 || p == 2) && $urandom_range(0, 19) == 0 && sb.pending() != 0) begin
          push_i <= 1'b0;
          while (sb.pending() != 0) @(posedge clk_i);
        end
        if ($urandom_range(0, 2) == 0) send_fu_frame();
        else send_other_packet();
      end
    end

    push_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
design/rtpd_pkg.sv
design/rtpd_front.sv
design/rtpd_cmd_fifo.sv
design/rtpd_back.sv
design/rtp_h264_depacketizer_unit.sv
bench/rtp_h264_depacketizer_unit_test.sv
